// ===== design/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_pkg - shared types and constants for the RGB to HSV converter
// Holds the fixed-point scale factors and the word that travels from the
// front-end stages into the divider lanes.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // Input and output field widths.
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned FIX_W   = 15;

  // Widths inside the divider lanes.
  localparam int unsigned NUM_W   = 23;   // half numerator, below 2**23
  localparam int unsigned RECIP_W = 24;   // floor(2**23 / d), up to 2**23
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned SECT_W  = 11;   // hue sector numerator, below 6*delta

  // Fixed-point scale factors.
  localparam logic [NUM_W-1:0] HUE_SIXTH = NUM_W'(3840);   // 60 degrees, 1/64 units
  localparam logic [FIX_W-1:0] HUE_FULL  = FIX_W'(23040);  // 360 degrees
  localparam logic [NUM_W-1:0] PCT_SCALE = NUM_W'(25600);  // 100 percent, 1/256 units

  // Word held in the second front-end stage.
  typedef struct packed {
    logic [NUM_W-1:0]   m_hue;
    logic [NUM_W-1:0]   m_sat;
    logic [RECIP_W-1:0] r_hue;
    logic [RECIP_W-1:0] r_sat;
    logic [LEVEL_W-1:0] d_hue;
    logic [LEVEL_W-1:0] d_sat;
    logic [FIX_W-1:0]   bright;
    logic [LEVEL_W-1:0] max_level;
    logic               grey;
  } prep_word_t;

endpackage

// ===== design/rgbhsv_prep.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_prep - front end of the RGB to HSV converter
// Stage A finds max, min, delta and the hue sector numerator. Stage B scales
// the numerators, looks up reciprocals of the divisors and the brightness.
// ----------------------------------------------------------------------------
module rgbhsv_prep (
  input  logic                              clk,
  input  logic                              en_a,
  input  logic                              en_b,
  input  logic [rgbhsv_pkg::LEVEL_W-1:0]    red,
  input  logic [rgbhsv_pkg::LEVEL_W-1:0]    green,
  input  logic [rgbhsv_pkg::LEVEL_W-1:0]    blue,
  output rgbhsv_pkg::prep_word_t            word_o
);

  localparam int unsigned LW = rgbhsv_pkg::LEVEL_W;
  localparam int unsigned NW = rgbhsv_pkg::NUM_W;
  localparam int unsigned RW = rgbhsv_pkg::RECIP_W;
  localparam int unsigned SW = rgbhsv_pkg::SECT_W;
  localparam int unsigned FW = rgbhsv_pkg::FIX_W;
  localparam int unsigned TAB_N = 1 << LW;

  // Sector offsets in units of delta: green starts at two, blue at four,
  // and a full turn is six.
  localparam logic signed [SW:0] SECT_GREEN = (SW + 1)'(2);
  localparam logic signed [SW:0] SECT_BLUE  = (SW + 1)'(4);
  localparam logic signed [SW:0] SECT_TURN  = (SW + 1)'(6);

  logic [LW-1:0] mx_nxt, mn_nxt, dl_nxt;
  logic [SW-1:0] t_nxt;
  logic signed [SW:0] t_s;
  logic signed [SW:0] d_s;

  logic [LW-1:0] mx_a_r, dl_a_r;
  logic [SW-1:0] t_a_r;

  logic [RW-1:0] recip_tab [TAB_N];
  logic [FW-1:0] bright_tab [TAB_N];

  rgbhsv_pkg::prep_word_t word_nxt;
  rgbhsv_pkg::prep_word_t word_b_r;

  // Reciprocal and brightness tables, worked out at elaboration.
  assign recip_tab[0]  = '0;
  assign bright_tab[0] = '0;
  for (genvar i = 1; i < TAB_N; i++) begin : g_tab
    localparam logic [RW-1:0] RECIP_V = RW'((64'd1 << rgbhsv_pkg::RECIP_SHIFT) / i);
    localparam logic [FW-1:0] BRIGHT_V = FW'((64'd51200 * i + 64'd255) / 64'd510);
    assign recip_tab[i]  = RECIP_V;
    assign bright_tab[i] = BRIGHT_V;
  end

  // Stage A: extremes, delta and the sector numerator (ties favor red, then green).
  always_comb begin
    mx_nxt = red;
    mn_nxt = red;
    if (green > mx_nxt) mx_nxt = green;
    if (blue  > mx_nxt) mx_nxt = blue;
    if (green < mn_nxt) mn_nxt = green;
    if (blue  < mn_nxt) mn_nxt = blue;
    dl_nxt = mx_nxt - mn_nxt;
    d_s    = $signed({{(SW + 1 - LW){1'b0}}, dl_nxt});
    if (red == mx_nxt) begin
      t_s = $signed({{(SW + 1 - LW){1'b0}}, green}) - $signed({{(SW + 1 - LW){1'b0}}, blue});
      if (t_s[SW]) t_s = t_s + SECT_TURN * d_s;
    end else if (green == mx_nxt) begin
      t_s = SECT_GREEN * d_s + $signed({{(SW + 1 - LW){1'b0}}, blue})
            - $signed({{(SW + 1 - LW){1'b0}}, red});
    end else begin
      t_s = SECT_BLUE * d_s + $signed({{(SW + 1 - LW){1'b0}}, red})
            - $signed({{(SW + 1 - LW){1'b0}}, green});
    end
    t_nxt = t_s[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      mx_a_r <= mx_nxt;
      dl_a_r <= dl_nxt;
      t_a_r  <= t_nxt;
    end
  end

  // Stage B: half numerators with the rounding term, reciprocal lookups.
  always_comb begin
    word_nxt.m_hue     = NW'(t_a_r) * rgbhsv_pkg::HUE_SIXTH + NW'(dl_a_r >> 1);
    word_nxt.m_sat     = NW'(dl_a_r) * rgbhsv_pkg::PCT_SCALE + NW'(mx_a_r >> 1);
    word_nxt.r_hue     = recip_tab[dl_a_r];
    word_nxt.r_sat     = recip_tab[mx_a_r];
    word_nxt.d_hue     = dl_a_r;
    word_nxt.d_sat     = mx_a_r;
    word_nxt.bright    = bright_tab[mx_a_r];
    word_nxt.max_level = mx_a_r;
    word_nxt.grey      = (dl_a_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      word_b_r <= word_nxt;
    end
  end

  assign word_o = word_b_r;

endmodule

// ===== design/rgbhsv_div.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_div - one divider lane by reciprocal multiplication
// Stage C estimates floor(m/d) from a reciprocal; the estimate is at most one
// low, so the output side checks the remainder and adds one where needed.
// ----------------------------------------------------------------------------
module rgbhsv_div (
  input  logic                             clk,
  input  logic                             en_c,
  input  logic [rgbhsv_pkg::NUM_W-1:0]     m_i,
  input  logic [rgbhsv_pkg::RECIP_W-1:0]   r_i,
  input  logic [rgbhsv_pkg::LEVEL_W-1:0]   d_i,
  output logic [rgbhsv_pkg::FIX_W-1:0]     q_o
);

  localparam int unsigned NW = rgbhsv_pkg::NUM_W;
  localparam int unsigned RW = rgbhsv_pkg::RECIP_W;
  localparam int unsigned FW = rgbhsv_pkg::FIX_W;
  localparam int unsigned LW = rgbhsv_pkg::LEVEL_W;
  localparam int unsigned SH = rgbhsv_pkg::RECIP_SHIFT;

  logic [NW+RW-1:0] prod;
  logic [FW-1:0]    q0_nxt;
  logic [FW-1:0]    q0_r;
  logic [NW-1:0]    m_r;
  logic [LW-1:0]    d_r;
  logic [NW-1:0]    back;
  logic [NW-1:0]    rem;

  // Stage C: quotient estimate.
  assign prod   = (NW + RW)'(m_i) * (NW + RW)'(r_i);
  assign q0_nxt = prod[SH+FW-1:SH];

  always_ff @(posedge clk) begin
    if (en_c) begin
      q0_r <= q0_nxt;
      m_r  <= m_i;
      d_r  <= d_i;
    end
  end

  // Correction: the remainder is below twice the divisor.
  assign back = NW'(q0_r) * NW'(d_r);
  assign rem  = m_r - back;
  assign q_o  = (rem >= NW'(d_r)) ? q0_r + FW'(1) : q0_r;

endmodule

// ===== design/rgb_to_hsv_converter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit - streaming RGB to HSV pixel converter
// Converts one 8-bit RGB pixel per word into hue, saturation, brightness and
// the raw maximum component, all exact with half-up rounding.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_*) takes one pixel per word; the output channel
//   (out_*) gives one result word per pixel, in order.
//   From an accepted input word to out_tvalid, each word passes two
//   front-end stages (extremes, then scaling and reciprocal lookup), one
//   reciprocal-multiply stage and the output register with the remainder
//   correction.
//   Without a stall, throughput is one word per cycle: each stage has its own
//   valid bit and loads when empty or when its successor moves; bubbles close up.
//   A stall at out_tready holds the output register; the stages behind it
//   keep filling until each holds a word, then in_tready drops.
//   Reset (rst_n low, synchronous) empties the pipeline; no result is lost
//   or repeated across a stall.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // hue [14:0], saturation [29:15],
                                  // brightness [44:30], max_level [52:45], zero [55:53]
);

  localparam int unsigned LW = rgbhsv_pkg::LEVEL_W;
  localparam int unsigned FW = rgbhsv_pkg::FIX_W;

  logic va_r, vb_r, vc_r, vo_r;
  logic en_a, en_b, en_c, en_o;

  rgbhsv_pkg::prep_word_t word_b;

  logic [FW-1:0] q_hue, q_sat;
  logic [FW-1:0] bright_c_r;
  logic [LW-1:0] max_c_r;
  logic          grey_c_r;

  logic [FW-1:0] hue_nxt, sat_nxt;
  logic [FW-1:0] hue_r, sat_r, bright_r;
  logic [LW-1:0] max_r;

  // Stage enables: a stage loads when it is empty or its word moves on.
  assign en_o = !vo_r || out_tready;
  assign en_c = !vc_r || en_o;
  assign en_b = !vb_r || en_c;
  assign en_a = !va_r || en_b;
  assign in_tready = en_a;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_tvalid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
      if (en_o) vo_r <= vc_r;
    end
  end

  // Front end.
  rgbhsv_prep u_prep (
    .clk    (clk),
    .en_a   (en_a),
    .en_b   (en_b),
    .red    (in_tdata[7:0]),
    .green  (in_tdata[15:8]),
    .blue   (in_tdata[23:16]),
    .word_o (word_b)
  );

  // Divider lanes for hue and saturation.
  rgbhsv_div u_div_hue (
    .clk  (clk),
    .en_c (en_c),
    .m_i  (word_b.m_hue),
    .r_i  (word_b.r_hue),
    .d_i  (word_b.d_hue),
    .q_o  (q_hue)
  );

  rgbhsv_div u_div_sat (
    .clk  (clk),
    .en_c (en_c),
    .m_i  (word_b.m_sat),
    .r_i  (word_b.r_sat),
    .d_i  (word_b.d_sat),
    .q_o  (q_sat)
  );

  // Side fields ride alongside the divider stage.
  always_ff @(posedge clk) begin
    if (en_c) begin
      bright_c_r <= word_b.bright;
      max_c_r    <= word_b.max_level;
      grey_c_r   <= word_b.grey;
    end
  end

  // A grey pixel has no hue or saturation; a full turn of hue wraps to zero.
  always_comb begin
    hue_nxt = q_hue;
    sat_nxt = q_sat;
    if (grey_c_r || q_hue == rgbhsv_pkg::HUE_FULL) hue_nxt = '0;
    if (grey_c_r) sat_nxt = '0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en_o) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= bright_c_r;
      max_r    <= max_c_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {3'b000, max_r, bright_r, sat_r, hue_r};

endmodule
